FILE: hw/rtl/gcdf_pkg.sv
package gcdf_pkg;

  localparam int unsigned BINS_X = 15;
  localparam int unsigned BINS_Y = 15;
  localparam int unsigned BINS_Z = 15;

  localparam int unsigned ADDR_W = 12;
  localparam int unsigned DEPTH  = 1 << ADDR_W;
  localparam int unsigned PROB_W = 17;
  localparam int unsigned BIN_W  = 8;

  localparam logic [PROB_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_POINT = 2'd1;
  localparam logic [1:0] KIND_BOX   = 2'd2;

  localparam logic [2:0] REG_X_ORG = 3'd0;
  localparam logic [2:0] REG_Y_ORG = 3'd1;
  localparam logic [2:0] REG_Z_ORG = 3'd2;
  localparam logic [2:0] REG_X_INV = 3'd3;
  localparam logic [2:0] REG_Y_INV = 3'd4;
  localparam logic [2:0] REG_Z_INV = 3'd5;

  // Controller to datapath
  typedef struct packed {
    logic       capture;
    logic       mul;
    logic       dec;
    logic [1:0] axis;
    logic [2:0] pt_idx;
    logic       is_box;
    logic       rd_en;
    logic [2:0] corner;
    logic       bl_a;
    logic       bl_b;
    logic [2:0] bl_cnt;
    logic       pt_acc;
    logic       out_load;
    logic [1:0] out_kind;
  } cmd_t;

  typedef struct packed {
    logic special;
  } sts_t;

  function automatic logic [31:0] bins_of(input logic [1:0] axis);
    case (axis)
      2'd0:    bins_of = 32'(BINS_X);
      2'd1:    bins_of = 32'(BINS_Y);
      default: bins_of = 32'(BINS_Z);
    endcase
  endfunction

  // Flat grid address, wraps modulo the table depth
  function automatic logic [ADDR_W-1:0] corner_addr(input logic [BIN_W-1:0] ix,
                                                    input logic [BIN_W-1:0] iy,
                                                    input logic [BIN_W-1:0] iz,
                                                    input logic [2:0] k);
    logic [ADDR_W-1:0] x, y, z;
    x = ADDR_W'(ix) + ADDR_W'(k[2]);
    y = ADDR_W'(iy) + ADDR_W'(k[1]);
    z = ADDR_W'(iz) + ADDR_W'(k[0]);
    corner_addr = (x * ADDR_W'(BINS_Y + 1) + y) * ADDR_W'(BINS_Z + 1) + z;
  endfunction

endpackage

FILE: hw/rtl/gcdf_ctrl.sv
module gcdf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      kind_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output gcdf_pkg::cmd_t  cmd_o,
  input  gcdf_pkg::sts_t  sts_i
);
  import gcdf_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL  = 4'd1;
  localparam logic [3:0] ST_DEC  = 4'd2;
  localparam logic [3:0] ST_CHK  = 4'd3;
  localparam logic [3:0] ST_RD   = 4'd4;
  localparam logic [3:0] ST_WAIT = 4'd5;
  localparam logic [3:0] ST_BLA  = 4'd6;
  localparam logic [3:0] ST_BLB  = 4'd7;
  localparam logic [3:0] ST_PACC = 4'd8;
  localparam logic [3:0] ST_FIN  = 4'd9;

  logic [3:0] state_q, state_d;
  logic [1:0] kind_q, kind_d;
  logic [1:0] axis_q, axis_d;
  logic [2:0] pt_q, pt_d;
  logic [2:0] cnt_q, cnt_d;
  logic       oval_q, oval_d;
  logic       accept;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign out_valid_o = oval_q;

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    axis_d  = axis_q;
    pt_d    = pt_q;
    cnt_d   = cnt_q;
    oval_d  = oval_q && out_stall_i;
    cmd_o          = '0;
    cmd_o.axis     = axis_q;
    cmd_o.pt_idx   = pt_q;
    cmd_o.is_box   = (kind_q == KIND_BOX);
    cmd_o.corner   = cnt_q;
    cmd_o.bl_cnt   = cnt_q;
    cmd_o.out_kind = kind_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          kind_d = kind_i;
          axis_d = 2'd0;
          pt_d   = 3'd0;
          if (kind_i == KIND_POINT || kind_i == KIND_BOX) state_d = ST_MUL;
          else state_d = ST_FIN;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = ST_DEC;
      end
      ST_DEC: begin
        cmd_o.dec = 1'b1;
        if (axis_q == 2'd2) begin
          state_d = ST_CHK;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      ST_CHK: begin
        cnt_d = 3'd0;
        state_d = sts_i.special ? ST_PACC : ST_RD;
      end
      ST_RD: begin
        cmd_o.rd_en = 1'b1;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) state_d = ST_WAIT;
      end
      ST_WAIT: begin
        cnt_d = 3'd0;
        state_d = ST_BLA;
      end
      ST_BLA: begin
        cmd_o.bl_a = 1'b1;
        state_d = ST_BLB;
      end
      ST_BLB: begin
        cmd_o.bl_b = 1'b1;
        cnt_d = cnt_q + 3'd1;
        state_d = (cnt_q == 3'd6) ? ST_PACC : ST_BLA;
      end
      ST_PACC: begin
        cmd_o.pt_acc = 1'b1;
        if (kind_q == KIND_BOX && pt_q != 3'd7) begin
          pt_d    = pt_q + 3'd1;
          axis_d  = 2'd0;
          state_d = ST_MUL;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!oval_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          oval_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= KIND_LOAD;
      axis_q  <= 2'd0;
      pt_q    <= 3'd0;
      cnt_q   <= 3'd0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      axis_q  <= axis_d;
      pt_q    <= pt_d;
      cnt_q   <= cnt_d;
      oval_q  <= oval_d;
    end
  end

endmodule

FILE: hw/rtl/gcdf_dp.sv
module gcdf_dp (
  input  logic                           clk_i,
  input  logic                           cfg_we_i,
  input  logic [2:0]                     cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           load_we_i,
  input  logic [gcdf_pkg::ADDR_W-1:0]    entry_index_i,
  input  logic [gcdf_pkg::PROB_W-1:0]    entry_value_i,
  input  logic signed [31:0]             x_a_i,
  input  logic signed [31:0]             y_a_i,
  input  logic signed [31:0]             z_a_i,
  input  logic signed [31:0]             x_b_i,
  input  logic signed [31:0]             y_b_i,
  input  logic signed [31:0]             z_b_i,
  input  gcdf_pkg::cmd_t                 cmd_i,
  output gcdf_pkg::sts_t                 sts_o,
  output logic [gcdf_pkg::PROB_W-1:0]    prob_value_o,
  output logic [1:0]                     done_kind_o,
  input  logic                           rst_ni
);
  import gcdf_pkg::*;

  logic signed [31:0] org_q [3];
  logic [31:0]        inv_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      inv_q[0] <= 32'h0001_0000;
      inv_q[1] <= 32'h0001_0000;
      inv_q[2] <= 32'h0001_0000;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_X_ORG: org_q[0] <= cfg_data_i;
        REG_Y_ORG: org_q[1] <= cfg_data_i;
        REG_Z_ORG: org_q[2] <= cfg_data_i;
        REG_X_INV: inv_q[0] <= cfg_data_i;
        REG_Y_INV: inv_q[1] <= cfg_data_i;
        REG_Z_INV: inv_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // grid store
  logic [PROB_W-1:0] mem [DEPTH];
  logic [PROB_W-1:0] rdata_q;
  logic [ADDR_W-1:0] raddr;

  always_ff @(posedge clk_i) begin
    if (load_we_i) mem[entry_index_i] <= entry_value_i;
    rdata_q <= mem[raddr];
  end

  // item coordinates
  logic signed [31:0] ca_q [3];
  logic signed [31:0] cb_q [3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ca_q[0] <= x_a_i; ca_q[1] <= y_a_i; ca_q[2] <= z_a_i;
      cb_q[0] <= x_b_i; cb_q[1] <= y_b_i; cb_q[2] <= z_b_i;
    end
  end

  // grid units, one axis at a time through one multiplier
  logic               use_b;
  logic signed [31:0] coord, org;
  logic signed [32:0] diff;
  logic [63:0]        prod_q;
  logic               below_q;
  logic [BIN_W-1:0]   bin_q [3];
  logic [PROB_W-1:0]  frac_q [3];
  logic [2:0]         beyond_q, neg_q;
  logic [31:0]        ip, nbins;

  always_comb begin
    case (cmd_i.axis)
      2'd0:    use_b = cmd_i.pt_idx[2];
      2'd1:    use_b = cmd_i.pt_idx[1];
      default: use_b = cmd_i.pt_idx[0];
    endcase
    use_b = use_b && cmd_i.is_box;
    coord = use_b ? cb_q[cmd_i.axis] : ca_q[cmd_i.axis];
    org   = org_q[cmd_i.axis];
    diff  = 33'(coord) - 33'(org);
    ip    = prod_q[63:32];
    nbins = bins_of(cmd_i.axis);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q  <= 64'(diff[31:0]) * 64'(inv_q[cmd_i.axis]);
      below_q <= diff[32] || (diff == '0);
    end
    if (cmd_i.dec) begin
      neg_q[cmd_i.axis] <= below_q;
      if (ip >= nbins) begin
        bin_q[cmd_i.axis]    <= BIN_W'(nbins - 32'd1);
        frac_q[cmd_i.axis]   <= ONE_Q16;
        beyond_q[cmd_i.axis] <= 1'b1;
      end else begin
        bin_q[cmd_i.axis]    <= ip[BIN_W-1:0];
        frac_q[cmd_i.axis]   <= {1'b0, prod_q[31:16]};
        beyond_q[cmd_i.axis] <= 1'b0;
      end
    end
  end

  assign sts_o.special = (|neg_q) || (&beyond_q);
  assign raddr = corner_addr(bin_q[0], bin_q[1], bin_q[2], cmd_i.corner);

  // corner words; blending pops the two at the head, result goes to the free tail
  logic [PROB_W-1:0] c_q [8];
  logic              pend_q;
  logic [2:0]        pidx_q;
  logic [PROB_W-1:0] f;
  logic [34:0]       macc_q;
  logic [34:0]       sum;
  logic [PROB_W-1:0] blend;
  logic [2:0]        wpos;

  always_comb begin
    if (cmd_i.bl_cnt < 3'd4)      f = frac_q[2];
    else if (cmd_i.bl_cnt < 3'd6) f = frac_q[1];
    else                          f = frac_q[0];
    sum   = macc_q + 35'(c_q[1]) * 35'(f) + 35'd32768;
    blend = sum[16 +: PROB_W];
    wpos  = 3'd6 - cmd_i.bl_cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pend_q <= 1'b0;
    else         pend_q <= cmd_i.rd_en;
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= cmd_i.corner;
    if (pend_q) c_q[pidx_q] <= rdata_q;
    if (cmd_i.bl_a) macc_q <= 35'(c_q[0]) * 35'(ONE_Q16 - f);
    if (cmd_i.bl_b) begin
      for (int i = 0; i < 6; i++) c_q[i] <= c_q[i+2];
      c_q[wpos] <= blend;
    end
  end

  // point value and box accumulation
  logic [PROB_W-1:0]  pt_val;
  logic               neg_sign;
  logic signed [20:0] acc_q;
  logic [PROB_W-1:0]  res;

  always_comb begin
    if (|neg_q)              pt_val = '0;
    else if (&beyond_q)      pt_val = ONE_Q16;
    else if (c_q[0] > ONE_Q16) pt_val = ONE_Q16;
    else                     pt_val = c_q[0];
    // odd number of corner-a picks subtracts
    neg_sign = cmd_i.is_box && (^(~cmd_i.pt_idx));
    if (acc_q <= 21'sd0)                res = '0;
    else if (acc_q > 21'sd65536)        res = ONE_Q16;
    else                                res = acc_q[PROB_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) acc_q <= '0;
    else if (cmd_i.pt_acc) begin
      if (neg_sign) acc_q <= acc_q - 21'(pt_val);
      else          acc_q <= acc_q + 21'(pt_val);
    end
    if (cmd_i.out_load) begin
      prob_value_o <= res;
      done_kind_o  <= cmd_i.out_kind;
    end
  end

endmodule

FILE: hw/rtl/grid_cdf_trilinear_lookup.sv
// Trilinear lookup into a 16x16x16-point grid of Q1.16 cumulative values.
// Input channel (in_valid_i/in_stall_o) takes one word per item: kind 0
// loads entry_value_i at entry_index_i, kind 1 evaluates the point
// (x_a, y_a, z_a), kind 2 returns the box mass between corners a and b.
// Each item yields one result word on out_valid_o/out_stall_i carrying
// prob_value_o and done_kind_o (zero value for a load).
// Items are handled one at a time by a state machine driving a single
// 32x32 multiplier for the grid-unit conversion, a grid RAM with one
// write and one read port (eight corner reads per point) and a shared
// multiply-accumulate blender. A box is 8 points. A point below the
// origin on any axis or beyond the far edge on all axes skips the corner
// reads and the seven blend steps that otherwise make up its work.
// The result sits in an output register; a new item is not taken until it
// has been placed there, so a stalled receiver holds the block in its final
// state. Configuration words (cfg_valid_i/cfg_ready_o) are always taken.
// Reset restores origins 0 and inverse widths 1.0; the grid itself is not
// cleared and every entry must be loaded before it is read.
module grid_cdf_trilinear_lookup (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            kind_i,
  input  logic [11:0]           entry_index_i,
  input  logic [16:0]           entry_value_i,
  input  logic signed [31:0]    x_a_i,
  input  logic signed [31:0]    y_a_i,
  input  logic signed [31:0]    z_a_i,
  input  logic signed [31:0]    x_b_i,
  input  logic signed [31:0]    y_b_i,
  input  logic signed [31:0]    z_b_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [16:0]           prob_value_o,
  output logic [1:0]            done_kind_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [31:0]           cfg_data_i
);
  import gcdf_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic load_we;

  assign cfg_ready_o = 1'b1;
  assign load_we = in_valid_i && !in_stall_o && (kind_i == KIND_LOAD);

  gcdf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  gcdf_dp u_dp (
    .clk_i         (clk_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .load_we_i     (load_we),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .x_a_i         (x_a_i),
    .y_a_i         (y_a_i),
    .z_a_i         (z_a_i),
    .x_b_i         (x_b_i),
    .y_b_i         (y_b_i),
    .z_b_i         (z_b_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .prob_value_o  (prob_value_o),
    .done_kind_o   (done_kind_o),
    .rst_ni        (rst_ni)
  );

endmodule

FILE: tb/grid_cdf_trilinear_lookup_tb.sv
module grid_cdf_trilinear_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gcdf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned SETTLE      = 300;
  localparam logic [1:0]  KIND_SPARE  = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] idx;
    logic [16:0] val;
    logic [31:0] xa, ya, za, xb, yb, zb;
  } item_t;

  typedef struct packed {
    logic [16:0] prob;
    logic [1:0]  kind;
  } word_t;

  // Mirror of the grid and registers; predicts one result word per accepted item
  class grid_cdf_model;
    logic [16:0] grid [DEPTH];
    logic [31:0] org [3];
    logic [31:0] inv [3];
    word_t       pending [$];
    int unsigned n_err, n_load, n_point, n_box, n_spare;

    function void reset_regs();
      for (int i = 0; i < 3; i++) begin
        org[i] = '0;
        inv[i] = 32'h10000;
      end
    endfunction

    function void set_reg(logic [2:0] r, logic [31:0] d);
      case (r)
        REG_X_ORG: org[0] = d;
        REG_Y_ORG: org[1] = d;
        REG_Z_ORG: org[2] = d;
        REG_X_INV: inv[0] = d;
        REG_Y_INV: inv[1] = d;
        REG_Z_INV: inv[2] = d;
        default: ;
      endcase
    endfunction

    function bit to_bins(int ax, logic [31:0] c, output int unsigned bin,
                         output longint unsigned frac, output bit past);
      longint      diff;
      logic [63:0] prod;
      logic [31:0] nb;
      nb   = bins_of(2'(ax));
      diff = longint'($signed(c)) - longint'($signed(org[ax]));
      past = 0;
      if (diff <= 0) return 0;
      prod = 64'(diff) * 64'(inv[ax]);
      if ((prod >> 32) >= 64'(nb)) begin
        bin  = nb - 1;
        frac = 65536;
        past = 1;
      end else begin
        bin  = int'(prod >> 32);
        frac = prod[31:16];
      end
      return 1;
    endfunction

    function longint unsigned mix(longint unsigned a, longint unsigned b,
                                  longint unsigned f);
      return (a * (65536 - f) + b * f + 32768) >> 16;
    endfunction

    function longint unsigned at(int unsigned x, int unsigned y, int unsigned z);
      return grid[((x * (BINS_Y + 1) + y) * (BINS_Z + 1) + z) % DEPTH];
    endfunction

    function longint point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      int unsigned     ix, iy, iz;
      longint unsigned fx, fy, fz, r;
      longint unsigned c [2][2];
      longint unsigned e [2];
      bit              bx, by, bz, ok;
      ok = to_bins(0, x, ix, fx, bx);
      ok = to_bins(1, y, iy, fy, by) && ok;
      ok = to_bins(2, z, iz, fz, bz) && ok;
      if (!ok) return 0;
      if (bx && by && bz) return 65536;
      for (int a = 0; a < 2; a++)
        for (int b = 0; b < 2; b++)
          c[a][b] = mix(at(ix + a, iy + b, iz), at(ix + a, iy + b, iz + 1), fz);
      for (int a = 0; a < 2; a++) e[a] = mix(c[a][0], c[a][1], fy);
      r = mix(e[0], e[1], fx);
      return (r > 65536) ? 65536 : r;
    endfunction

    function void note_item(item_t it);
      word_t  w;
      longint d;
      w.kind = it.kind;
      w.prob = '0;
      case (it.kind)
        KIND_LOAD: begin
          grid[it.idx] = it.val;
          n_load++;
        end
        KIND_POINT: begin
          w.prob = 17'(point(it.xa, it.ya, it.za));
          n_point++;
        end
        KIND_BOX: begin
          d = point(it.xb, it.yb, it.zb) - point(it.xb, it.ya, it.zb)
            - point(it.xa, it.yb, it.zb) + point(it.xa, it.ya, it.zb)
            - point(it.xb, it.yb, it.za) + point(it.xb, it.ya, it.za)
            + point(it.xa, it.yb, it.za) - point(it.xa, it.ya, it.za);
          w.prob = (d <= 0) ? '0 : (d > 65536) ? ONE_Q16 : 17'(d);
          n_box++;
        end
        default: n_spare++;
      endcase
      pending.push_back(w);
    endfunction

    function void check_word(logic [16:0] prob, logic [1:0] kind);
      word_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word prob=%0d kind=%0d", $realtime, prob, kind);
        n_err++;
        return;
      end
      w = pending.pop_front();
      if (prob !== w.prob) begin
        $display("%0t: prob_value expected %0d got %0d", $realtime, w.prob, prob);
        n_err++;
      end
      if (kind !== w.kind) begin
        $display("%0t: done_kind expected %0d got %0d", $realtime, w.kind, kind);
        n_err++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [1:0]  kind_i = '0;
  logic [11:0] entry_index_i = '0;
  logic [16:0] entry_value_i = '0;
  logic signed [31:0] x_a_i = '0, y_a_i = '0, z_a_i = '0;
  logic signed [31:0] x_b_i = '0, y_b_i = '0, z_b_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1;
  logic [16:0] prob_value_o;
  logic [1:0]  done_kind_o;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  grid_cdf_trilinear_lookup i_dut (.*);

  grid_cdf_model model = new();
  bit            calm;
  int unsigned   cycles;

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL grid_cdf_trilinear_lookup");
      $finish;
    end
  end

  // receiving side
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = calm ? 0 : $urandom_range(0, 16);
      if (n > 0) begin
        out_stall_i <= 1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 0;
      do @(posedge clk_i); while (!out_valid_o);
      model.check_word(prob_value_o, done_kind_o);
    end
  end

  task automatic send(item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1;
    kind_i        <= it.kind;
    entry_index_i <= it.idx;
    entry_value_i <= it.val;
    x_a_i <= it.xa; y_a_i <= it.ya; z_a_i <= it.za;
    x_b_i <= it.xb; y_b_i <= it.yb; z_b_i <= it.zb;
    do @(posedge clk_i); while (in_stall_o);
    model.note_item(it);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (model.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] r, logic [31:0] d);
    @(posedge clk_i);
    cfg_valid_i <= 1;
    cfg_index_i <= r;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    model.set_reg(r, d);
  endtask

  // coordinate landing mostly inside the grid under the current registers
  function automatic logic [31:0] near(int ax);
    int     gu;
    longint delta;
    gu = int'($urandom_range(0, 17 * 65536)) - 32768;
    if (model.inv[ax] == 0) delta = $urandom_range(0, 1 << 20);
    else delta = (longint'(gu) <<< 16) / longint'(model.inv[ax]);
    return 32'(longint'($signed(model.org[ax])) + delta);
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int    r;
    it = '{kind: KIND_POINT, idx: 12'($urandom), val: 17'($urandom_range(0, 65536)),
           xa: $urandom, ya: $urandom, za: $urandom,
           xb: $urandom, yb: $urandom, zb: $urandom};
    r = $urandom_range(0, 99);
    if (r < 10) it.kind = KIND_LOAD;
    else if (r < 15) it.kind = KIND_SPARE;
    else if (r < 25) it.kind = ($urandom_range(0, 1) != 0) ? KIND_BOX : KIND_POINT;
    else begin
      it.kind = (r < 60) ? KIND_POINT : KIND_BOX;
      it.xa = near(0); it.ya = near(1); it.za = near(2);
      it.xb = near(0); it.yb = near(1); it.zb = near(2);
    end
    return it;
  endfunction

  function automatic item_t pt(logic [1:0] k, logic [31:0] xa, ya, za, xb, yb, zb);
    return '{kind: k, idx: '0, val: '0, xa: xa, ya: ya, za: za, xb: xb, yb: yb, zb: zb};
  endfunction

  initial begin
    item_t       it;
    logic [31:0] o [3];
    logic [31:0] v [3];
    int          ix, iy, iz;
    model.reset_regs();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // fill every entry first, so no corner read ever hits an unwritten word
    calm = 1;
    for (int a = 0; a < DEPTH; a++) begin
      ix = a / 256; iy = (a / 16) % 16; iz = a % 16;
      it = '0;
      it.kind = KIND_LOAD;
      it.idx  = 12'(a);
      it.val  = 17'(((ix + 1) * (iy + 1) * (iz + 1) * 65536) / 4096);
      send(it);
    end
    calm = 0;

    // directed words under reset registers (one bin is 1.0)
    send('{kind: KIND_LOAD, idx: 12'd0, val: 17'd0, default: '0});
    send('{kind: KIND_LOAD, idx: 12'hFFF, val: ONE_Q16, default: '0});
    send('{kind: KIND_LOAD, idx: 12'h111, val: ONE_Q16, default: '0});
    send(pt(KIND_POINT, 32'h0, 32'h10000, 32'h10000, 0, 0, 0));       // on origin
    send(pt(KIND_POINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0));
    send(pt(KIND_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
    send(pt(KIND_POINT, 32'hF_0000, 32'hF_0000, 32'hF_0000, 0, 0, 0)); // far edge all
    send(pt(KIND_POINT, 32'h20_0000, 32'h8000, 32'h8000, 0, 0, 0));    // one axis past
    send(pt(KIND_POINT, 32'hE_FFFF, 32'hE_FFFF, 32'hE_FFFF, 0, 0, 0)); // last bin
    send(pt(KIND_POINT, 32'h1, 32'h1, 32'h1, 0, 0, 0));
    send(pt(KIND_POINT, 32'h1_0000, 32'h1_0000, 32'h1_0000, 0, 0, 0)); // fraction zero
    send(pt(KIND_POINT, 32'h1_FFFF, 32'h2_FFFF, 32'h3_FFFF, 0, 0, 0)); // fraction max
    send(pt(KIND_BOX, 32'h1_0000, 32'h1_0000, 32'h1_0000,
            32'h8_8000, 32'h9_4000, 32'h7_C000));
    send(pt(KIND_BOX, 32'h8_8000, 32'h9_4000, 32'h7_C000,
            32'h1_0000, 32'h1_0000, 32'h1_0000));                      // swapped corners
    send(pt(KIND_BOX, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));             // whole grid
    send(pt(KIND_BOX, 32'h3_0000, 32'h3_0000, 32'h3_0000,
            32'h3_0000, 32'h3_0000, 32'h3_0000));                      // empty box
    send(pt(KIND_SPARE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
    send('{kind: KIND_SPARE, idx: 12'hFFF, val: 17'h1FFFF, default: '1});

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      for (int a = 0; a < 3; a++) begin
        case (ph)
          0: begin o[a] = '0;           v[a] = 32'h10000; end
          1: begin o[a] = 32'h8000_0000; v[a] = 32'hFFFF_FFFF; end
          2: begin o[a] = 32'h7FFF_FFFF; v[a] = '0; end
          3: begin o[a] = 32'($urandom_range(0, 1 << 24)) - 32'h80_0000;
                   v[a] = $urandom_range(1 << 12, 1 << 20); end
          default: begin o[a] = $urandom; v[a] = $urandom; end
        endcase
      end
      for (int a = 0; a < 3; a++) write_reg(REG_X_ORG + 3'(a), o[a]);
      for (int a = 0; a < 3; a++) write_reg(REG_X_INV + 3'(a), v[a]);
      for (int n = 0; n < 120; n++) begin
        if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        if (ph == 3 && n == 60) begin
          in_valid_i <= 0;
          while (model.pending.size() != 0) @(posedge clk_i);
        end
        send(rand_item());
      end
      calm = 0;
    end
    drain();

    $display("Covered %0d loads, %0d point and %0d box queries, %0d spare-kind words",
             model.n_load, model.n_point, model.n_box, model.n_spare);
    $display("across five register settings including both extremes of origin and width.");
    if (model.n_err == 0) begin
      $display("PASS grid_cdf_trilinear_lookup");
    end else begin
      $display("FAIL grid_cdf_trilinear_lookup");
    end
    $finish;
  end

endmodule
